### hdl/rofr_pkg.sv
// ----------------------------------------------------------------------------
// rofr_pkg
// Shared types and codes for the rectangle outline and fill drawing engine.
// ----------------------------------------------------------------------------
package rofr_pkg;

   // request kinds, equal to the action codes on the request channel
   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_POINT   = 2'd1,
      KIND_OUTLINE = 2'd2,
      KIND_FILL    = 2'd3
   } kind_type;

   // drawing state of the back end
   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_OUTLINE = 2'd2,
      MODE_FILL    = 2'd3
   } mode_type;

   // response status codes
   localparam logic [1:0] STATUS_WRITE  = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_BUSY   = 2'd2;

   localparam logic [23:0] FRAME_BASE_RESET = 24'hC00000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // classified request as it travels from front to back
   typedef struct packed {
      kind_type    kind;
      logic        reject;
      logic [9:0]  left_col;
      logic [9:0]  right_col;
      logic [9:0]  top_row;
      logic [9:0]  bottom_row;
      logic [15:0] colour;
      logic [23:0] row_addr;
   } item_type;

endpackage

### hdl/rect_outline_fill_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// rect_outline_fill_rasterizer_unit
// Frame-buffer drawing engine for points, box outlines and filled boxes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries commands (tuser = action) and ticks. A point, outline or
//   fill command taken while idle gives its first pixel write; each later
//   tick gives the next write in raster order, tlast on the final one.
//   A command arriving while a box runs gives a busy response; a command
//   whose start lies off screen memory gives a reject response with tlast.
//   A tick while idle gives no response. rsp_* carries pixel writes and
//   status (tuser); csr_wr_* sets the frame base address, which the user
//   must write only while the engine is idle; the block does not enforce it.
// Timing:
//   while rsp_tready is high, one request per cycle is sustained. The
//   front classifies, a four-entry queue decouples it from the cursor unit,
//   which emits one write per cycle while ticks come and rsp_tready is high.
//   The cursor keeps a running row address, so no multiply sits in its loop.
// Reset clears the queue, the drawing state and the response valid, and
// sets the frame base to 0xC00000. While rsp_tready is low the response
// holds, the queue fills and req_tready drops once it is full.
// ----------------------------------------------------------------------------
module rect_outline_fill_rasterizer_unit import rofr_pkg::*; #(
   parameter int SCREEN_COLS = 512,
   parameter int SCREEN_ROWS = 512,
   parameter int PIXEL_BYTES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // x_first, y_first, x_second, y_second, colour
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pixel_address, pixel_colour
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast    // last_of_command
);

   logic     queue_full, queue_push, queue_valid, queue_pop;
   item_type push_item, pop_item;

   rofr_front #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS),
      .PIXEL_BYTES (PIXEL_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_item  (push_item)
   );

   rofr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_item  (pop_item)
   );

   rofr_back #(
      .SCREEN_COLS (SCREEN_COLS),
      .PIXEL_BYTES (PIXEL_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_item  (pop_item),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### hdl/rofr_front.sv
// ----------------------------------------------------------------------------
// rofr_front
// Accepts requests, sorts and clips box corners, checks the start address
// and forms the byte address of the start row.
// ----------------------------------------------------------------------------
module rofr_front import rofr_pkg::*; #(
   parameter int SCREEN_COLS = 512,
   parameter int SCREEN_ROWS = 512,
   parameter int PIXEL_BYTES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        queue_full,
   output logic        queue_push,
   output item_type    queue_item
);

   localparam int ROW_BYTES  = SCREEN_COLS * PIXEL_BYTES;
   localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;

   logic [23:0] frame_base_ff, frame_base_in;

   logic [9:0]  x_first, y_first, x_second, y_second;
   logic [15:0] colour;
   kind_type    kind;
   logic        is_box;
   logic [9:0]  x_lo, x_hi, y_lo, y_hi, x_clip, y_clip;
   logic [9:0]  start_col, start_row;
   logic [20:0] cell_offset;
   logic        off_memory;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= FRAME_BASE_RESET;
      end else begin
         frame_base_ff <= frame_base_in;
      end
   end

   assign frame_base_in = csr_wr_en ? csr_wr_data : frame_base_ff;

   assign x_first  = req_tdata[9:0];
   assign y_first  = req_tdata[19:10];
   assign x_second = req_tdata[29:20];
   assign y_second = req_tdata[39:30];
   assign colour   = req_tdata[55:40];
   assign kind     = kind_type'(req_tuser);
   assign is_box   = (kind == KIND_OUTLINE) || (kind == KIND_FILL);

   always_comb begin
      x_lo = (x_first > x_second) ? x_second : x_first;
      x_hi = (x_first > x_second) ? x_first : x_second;
      y_lo = (y_first > y_second) ? y_second : y_first;
      y_hi = (y_first > y_second) ? y_first : y_second;
      x_clip = ({1'b0, x_hi} >= 11'(SCREEN_COLS)) ? 10'(SCREEN_COLS - 1) : x_hi;
      y_clip = ({1'b0, y_hi} >= 11'(SCREEN_ROWS)) ? 10'(SCREEN_ROWS - 1) : y_hi;
      start_col = is_box ? x_lo : x_first;
      start_row = is_box ? y_lo : y_first;
      // start offset in pixels; the pixel size cancels out of the limit test
      cell_offset = 21'(start_row) * 21'(SCREEN_COLS) + 21'(start_col);
      off_memory  = cell_offset >= 21'(CELL_COUNT);
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;

   always_comb begin
      queue_item.kind       = kind;
      queue_item.reject     = off_memory || (is_box && (x_lo > x_clip));
      queue_item.left_col   = start_col;
      queue_item.right_col  = x_clip;
      queue_item.top_row    = start_row;
      queue_item.bottom_row = y_clip;
      queue_item.colour     = colour;
      queue_item.row_addr   = frame_base_ff + 24'(start_row) * 24'(ROW_BYTES);
   end

endmodule

### hdl/rofr_queue.sv
// ----------------------------------------------------------------------------
// rofr_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module rofr_queue import rofr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_pop;

   assign full      = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/rofr_back.sv
// ----------------------------------------------------------------------------
// rofr_back
// Runs the raster cursor for boxes and drives the registered response.
// ----------------------------------------------------------------------------
module rofr_back import rofr_pkg::*; #(
   parameter int SCREEN_COLS = 512,
   parameter int PIXEL_BYTES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_valid,
   input  item_type    queue_item,
   output logic        queue_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int ROW_BYTES = SCREEN_COLS * PIXEL_BYTES;

   mode_type    mode_ff, mode_in;
   logic [9:0]  col_ff, col_in, row_ff, row_in;
   logic [9:0]  left_ff, left_in, right_ff, right_in;
   logic [9:0]  top_ff, top_in, bottom_ff, bottom_in;
   logic        rsn_ff, rsn_in;
   logic [15:0] colour_ff, colour_in;
   logic [23:0] row_addr_ff, row_addr_in;

   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_addr_ff, out_addr_in;
   logic [15:0] out_colour_ff, out_colour_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;

   logic [9:0]  adv_col, adv_row;
   logic        adv_rsn;
   logic [23:0] adv_row_addr;
   logic        adv_last;
   logic [9:0]  sel_col;
   logic [23:0] sel_row_addr, sel_addr;
   logic        emit;

   assign queue_pop = queue_valid && (!out_valid_ff || rsp_tready);

   // next cursor position in raster order
   always_comb begin
      adv_col      = col_ff;
      adv_row      = row_ff;
      adv_rsn      = rsn_ff;
      adv_row_addr = row_addr_ff;
      if ((mode_ff == MODE_FILL) || (row_ff == top_ff) || (row_ff == bottom_ff)) begin
         if (col_ff < right_ff) begin
            adv_col = col_ff + 1'b1;
         end else begin
            adv_row      = row_ff + 1'b1;
            adv_col      = left_ff;
            adv_rsn      = 1'b0;
            adv_row_addr = row_addr_ff + 24'(ROW_BYTES);
         end
      end else if (rsn_ff) begin
         adv_col = right_ff;
         adv_rsn = 1'b0;
      end else begin
         adv_row      = row_ff + 1'b1;
         adv_col      = left_ff;
         adv_rsn      = 1'b0;
         adv_row_addr = row_addr_ff + 24'(ROW_BYTES);
      end
      // side rows of an outline write the left pixel, then the right one
      if ((mode_ff == MODE_OUTLINE) && (adv_row != top_ff) && (adv_row != bottom_ff)
          && (adv_col == left_ff) && (right_ff > left_ff)) begin
         adv_rsn = 1'b1;
      end
      adv_last = (adv_row == bottom_ff) && (adv_col == right_ff);
   end

   always_comb begin
      mode_in     = mode_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      rsn_in      = rsn_ff;
      colour_in   = colour_ff;
      row_addr_in = row_addr_ff;

      emit          = 1'b0;
      out_addr_in   = out_addr_ff;
      out_colour_in = out_colour_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (queue_item.kind == KIND_TICK) begin
         sel_col      = adv_col;
         sel_row_addr = adv_row_addr;
      end else begin
         sel_col      = queue_item.left_col;
         sel_row_addr = queue_item.row_addr;
      end
      sel_addr = sel_row_addr + 24'(sel_col) * 24'(PIXEL_BYTES);

      if (queue_pop) begin
         case (queue_item.kind)
            KIND_TICK: begin
               if (mode_ff != MODE_IDLE) begin
                  col_in        = adv_col;
                  row_in        = adv_row;
                  rsn_in        = adv_rsn;
                  row_addr_in   = adv_row_addr;
                  emit          = 1'b1;
                  out_addr_in   = sel_addr;
                  out_colour_in = colour_ff;
                  out_status_in = STATUS_WRITE;
                  out_last_in   = adv_last;
                  if (adv_last) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
            default: begin
               emit = 1'b1;
               if (mode_ff != MODE_IDLE) begin
                  out_addr_in   = '0;
                  out_colour_in = '0;
                  out_status_in = STATUS_BUSY;
                  out_last_in   = 1'b0;
               end else if (queue_item.reject) begin
                  out_addr_in   = '0;
                  out_colour_in = '0;
                  out_status_in = STATUS_REJECT;
                  out_last_in   = 1'b1;
               end else if (queue_item.kind == KIND_POINT) begin
                  out_addr_in   = sel_addr;
                  out_colour_in = queue_item.colour;
                  out_status_in = STATUS_WRITE;
                  out_last_in   = 1'b1;
               end else begin
                  col_in        = queue_item.left_col;
                  row_in        = queue_item.top_row;
                  left_in       = queue_item.left_col;
                  right_in      = queue_item.right_col;
                  top_in        = queue_item.top_row;
                  bottom_in     = queue_item.bottom_row;
                  rsn_in        = 1'b0;
                  colour_in     = queue_item.colour;
                  row_addr_in   = queue_item.row_addr;
                  out_addr_in   = sel_addr;
                  out_colour_in = queue_item.colour;
                  out_status_in = STATUS_WRITE;
                  out_last_in   = (queue_item.top_row == queue_item.bottom_row)
                                  && (queue_item.left_col == queue_item.right_col);
                  if (out_last_in) begin
                     mode_in = MODE_IDLE;
                  end else if (queue_item.kind == KIND_OUTLINE) begin
                     mode_in = MODE_OUTLINE;
                  end else begin
                     mode_in = MODE_FILL;
                  end
               end
            end
         endcase
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         top_ff       <= '0;
         bottom_ff    <= '0;
         rsn_ff       <= 1'b0;
         colour_ff    <= '0;
         row_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
         rsn_ff       <= rsn_in;
         colour_ff    <= colour_in;
         row_addr_ff  <= row_addr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_addr_ff   <= out_addr_in;
      out_colour_ff <= out_colour_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_colour_ff, out_addr_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### hdl/rofr_checker.sv
// ----------------------------------------------------------------------------
// rofr_checker
// Port-level checks on the response channel of the drawing engine.
// ----------------------------------------------------------------------------
module rofr_checker import rofr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // status is one of the three codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_WRITE) || (rsp_tuser == STATUS_REJECT)
         || (rsp_tuser == STATUS_BUSY))
      else $error("unknown status code");

   // reject ends the command and carries no pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_REJECT) |-> rsp_tlast && (rsp_tdata == '0))
      else $error("malformed reject response");

   // busy never ends the running command and carries no pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_BUSY) |-> !rsp_tlast && (rsp_tdata == '0))
      else $error("malformed busy response");

endmodule

bind rect_outline_fill_rasterizer_unit rofr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### verif/tb_rect_outline_fill_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_outline_fill_rasterizer_unit
// Drives points, outlines, fills and ticks into the drawing engine under
// random stalls on both sides. A scoreboard predicts every pixel write,
// reject and busy response and checks each response against it in order.
// ----------------------------------------------------------------------------
module tb_rect_outline_fill_rasterizer_unit;
   import rofr_pkg::*;

   localparam int SCREEN_COLS = 512;
   localparam int SCREEN_ROWS = 512;
   localparam int PIXEL_BYTES = 2;

   typedef struct {
      logic [23:0] addr;
      logic [15:0] colour;
      logic [1:0]  status;
      logic        last;
   } pixel_write_type;

   typedef enum {SINK_READY, SINK_COIN, SINK_MOSTLY, SINK_PERIODIC} sink_pattern_type;

   class draw_scoreboard;
      logic [23:0]     frame_base;
      mode_type        mode;
      logic [9:0]      cur_col;
      logic [9:0]      cur_row;
      logic [9:0]      left_col;
      logic [9:0]      right_col;
      logic [9:0]      top_row;
      logic [9:0]      bottom_row;
      logic            right_next;
      logic [15:0]     draw_colour;
      pixel_write_type expected_q[$];
      int              failures;

      function new();
         frame_base  = FRAME_BASE_RESET;
         mode        = MODE_IDLE;
         cur_col     = '0;
         cur_row     = '0;
         left_col    = '0;
         right_col   = '0;
         top_row     = '0;
         bottom_row  = '0;
         right_next  = 1'b0;
         draw_colour = '0;
         failures    = 0;
      endfunction

      // unwrapped byte address, so the memory limit test sees the carry
      function logic [63:0] byte_addr(input logic [9:0] col, input logic [9:0] row);
         return 64'(frame_base) + 64'(row) * SCREEN_COLS * PIXEL_BYTES
              + 64'(col) * PIXEL_BYTES;
      endfunction

      function logic [63:0] mem_limit();
         return 64'(frame_base) + 64'(SCREEN_COLS) * SCREEN_ROWS * PIXEL_BYTES;
      endfunction

      function void push_write(input logic [23:0] addr, input logic [15:0] colour,
                               input logic [1:0] status, input logic last);
         pixel_write_type w;
         w.addr   = addr;
         w.colour = colour;
         w.status = status;
         w.last   = last;
         expected_q.push_back(w);
      endfunction

      function void push_cursor_write();
         logic [63:0] a;
         logic        last;
         a    = byte_addr(cur_col, cur_row);
         last = (cur_row == bottom_row) && (cur_col == right_col);
         push_write(a[23:0], draw_colour, STATUS_WRITE, last);
         if (last)
            mode = MODE_IDLE;
      endfunction

      function void note_request(input kind_type kind, input logic [9:0] xa,
                                 input logic [9:0] ya, input logic [9:0] xb,
                                 input logic [9:0] yb, input logic [15:0] colour);
         logic [9:0]  t;
         logic [63:0] start;
         if (kind == KIND_TICK) begin
            if (mode == MODE_IDLE)
               return;
            if (mode == MODE_FILL || cur_row == top_row || cur_row == bottom_row) begin
               if (cur_col < right_col) begin
                  cur_col = cur_col + 10'd1;
               end else begin
                  cur_row    = cur_row + 10'd1;
                  cur_col    = left_col;
                  right_next = 1'b0;
               end
            end else if (right_next) begin
               cur_col    = right_col;
               right_next = 1'b0;
            end else begin
               cur_row    = cur_row + 10'd1;
               cur_col    = left_col;
               right_next = 1'b0;
            end
            // side rows of an outline take the left pixel, then jump right
            if (mode == MODE_OUTLINE && cur_row != top_row && cur_row != bottom_row
                && cur_col == left_col && right_col > left_col)
               right_next = 1'b1;
            push_cursor_write();
            return;
         end
         if (mode != MODE_IDLE) begin
            push_write('0, '0, STATUS_BUSY, 1'b0);
            return;
         end
         if (kind == KIND_POINT) begin
            start = byte_addr(xa, ya);
            if (start >= mem_limit())
               push_write('0, '0, STATUS_REJECT, 1'b1);
            else
               push_write(start[23:0], colour, STATUS_WRITE, 1'b1);
            return;
         end
         if (xa > xb) begin
            t  = xa;
            xa = xb;
            xb = t;
         end
         if (ya > yb) begin
            t  = ya;
            ya = yb;
            yb = t;
         end
         if (xb >= SCREEN_COLS)
            xb = 10'(SCREEN_COLS - 1);
         if (yb >= SCREEN_ROWS)
            yb = 10'(SCREEN_ROWS - 1);
         start = byte_addr(xa, ya);
         if (start >= mem_limit() || xa > xb) begin
            push_write('0, '0, STATUS_REJECT, 1'b1);
            return;
         end
         left_col    = xa;
         right_col   = xb;
         top_row     = ya;
         bottom_row  = yb;
         cur_col     = xa;
         cur_row     = ya;
         right_next  = 1'b0;
         draw_colour = colour;
         mode        = (kind == KIND_FILL) ? MODE_FILL : MODE_OUTLINE;
         push_cursor_write();
      endfunction

      function void check_response(input logic [23:0] addr, input logic [15:0] colour,
                                   input logic [1:0] status, input logic last);
         pixel_write_type w;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected response addr %h colour %h status %0d last %0b",
                        $time, addr, colour, status, last);
            return;
         end
         w = expected_q.pop_front();
         if (addr !== w.addr || colour !== w.colour || status !== w.status
             || last !== w.last) begin
            failures++;
            if (failures <= 10)
               $display({"%0t: mismatch expected addr %h colour %h status %0d last %0b,",
                         " got addr %h colour %h status %0d last %0b"},
                        $time, w.addr, w.colour, w.status, w.last,
                        addr, colour, status, last);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [23:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata   = '0;   // x_first, y_first, x_second, y_second, colour
   logic [1:0]  req_tuser   = '0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;          // pixel_address, pixel_colour
   logic [1:0]  rsp_tuser;          // status
   logic        rsp_tlast;          // last_of_command

   draw_scoreboard sb = new();
   int             burst_left = 1;
   int             hold_requests = 0;

   rect_outline_fill_rasterizer_unit #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS),
      .PIXEL_BYTES(PIXEL_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // response side: own stall pattern plus an occasional long hold-off
   initial begin : response_sink
      int               hold_left;
      int               hold_seen;
      int               cycle_count;
      sink_pattern_type pattern;
      hold_left   = 0;
      hold_seen   = 0;
      cycle_count = 0;
      pattern     = SINK_READY;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[23:0], rsp_tdata[39:24], rsp_tuser, rsp_tlast);
         cycle_count++;
         if (cycle_count % 300 == 0)
            pattern = sink_pattern_type'($urandom_range(0, 3));
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (pattern)
               SINK_READY:  rsp_tready <= 1'b1;
               SINK_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               SINK_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
               default:     rsp_tready <= (cycle_count % 5 != 0);
            endcase
         end
      end
   end

   task automatic send_item(input kind_type kind, input logic [9:0] xa, input logic [9:0] ya,
                            input logic [9:0] xb, input logic [9:0] yb,
                            input logic [15:0] colour);
      int gap;
      req_tdata  <= {colour, yb, xb, ya, xa};
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, xa, ya, xb, yb, colour);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // tick with junk in the unused fields
   task automatic send_tick();
      send_item(KIND_TICK, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                16'($urandom));
   endtask

   task automatic finish_box();
      while (sb.mode != MODE_IDLE) send_tick();
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_frame_base(input logic [23:0] base);
      finish_box();
      drain_responses();
      csr_wr_data <= base;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.frame_base = base;
   endtask

   task automatic send_random_command();
      kind_type   kind;
      logic [9:0] xa, ya, xb, yb, t;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 25)
         kind = KIND_POINT;
      else if (r < 60)
         kind = KIND_OUTLINE;
      else
         kind = KIND_FILL;
      r = $urandom_range(0, 19);
      if (r < 14) begin
         xa = 10'($urandom_range(0, 511));
         ya = 10'($urandom_range(0, 511));
         xb = xa + 10'($urandom_range(0, 7));
         yb = ya + 10'($urandom_range(0, 5));
      end else if (r < 19) begin
         // near the far edges: clipping and off-screen rejects
         xa = 10'($urandom_range(500, 1023));
         ya = 10'($urandom_range(500, 1023));
         xb = 10'($urandom_range(500, 1023));
         yb = 10'($urandom_range(500, 1023));
      end else begin
         // any start, single-row box
         xa = 10'($urandom);
         ya = 10'($urandom);
         xb = 10'($urandom);
         yb = ya;
      end
      if ($urandom_range(0, 1)) begin
         t  = xa;
         xa = xb;
         xb = t;
      end
      if ($urandom_range(0, 1)) begin
         t  = ya;
         ya = yb;
         yb = t;
      end
      if (kind == KIND_POINT) begin
         xb = 10'($urandom);
         yb = 10'($urandom);
      end
      send_item(kind, xa, ya, xb, yb, 16'($urandom));
   endtask

   task automatic run_random(input int n_items, input bit with_pressure);
      int sent;
      bit held, paused;
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (sent < n_items) begin
         if (with_pressure && !held && sent >= n_items / 3) begin
            held = 1'b1;
            hold_requests++;
         end
         if (with_pressure && !paused && sent >= 2 * n_items / 3) begin
            paused = 1'b1;
            drain_responses();
         end
         if (sb.mode == MODE_IDLE && $urandom_range(0, 15) == 0) begin
            send_tick();   // ignored while idle
         end else begin
            if (sb.mode != MODE_IDLE && $urandom_range(0, 19) != 0)
               send_tick();
            else
               send_random_command();
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      logic [23:0] bases[4];
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_tick();
      send_item(KIND_POINT, 0, 0, 1023, 1023, 16'hFFFF);
      send_item(KIND_POINT, 511, 511, 0, 0, 16'h0000);
      send_item(KIND_POINT, 600, 3, 0, 0, 16'h1234);   // spills into the next row
      send_item(KIND_POINT, 1023, 1023, 1023, 1023, 16'h8001);
      send_item(KIND_OUTLINE, 5, 4, 2, 1, 16'hA5A5);   // corners given reversed
      send_tick();
      send_item(KIND_FILL, 1, 1, 2, 2, 16'h5A5A);      // busy
      send_item(KIND_POINT, 7, 7, 0, 0, 16'h0F0F);     // busy
      finish_box();
      send_item(KIND_FILL, 3, 3, 5, 4, 16'h00FF);
      finish_box();
      send_item(KIND_OUTLINE, 10, 7, 14, 7, 16'hFF00);
      finish_box();
      send_item(KIND_OUTLINE, 9, 2, 9, 6, 16'h3C3C);
      finish_box();
      send_item(KIND_FILL, 8, 8, 8, 8, 16'hC3C3);
      send_item(KIND_OUTLINE, 20, 30, 20, 30, 16'h1111);
      send_item(KIND_FILL, 1023, 1023, 509, 508, 16'h2222);
      finish_box();
      send_item(KIND_OUTLINE, 600, 5, 700, 9, 16'h3333);   // left column off screen
      send_item(KIND_FILL, 5, 600, 9, 700, 16'h4444);      // start past memory end
      send_item(KIND_OUTLINE, 480, 490, 1023, 1023, 16'h5555);   // clipped on both edges
      finish_box();

      run_random(340, 1'b1);
      bases[0] = 24'h000000;
      bases[1] = 24'hFFFFFF;
      bases[2] = 24'($urandom);
      bases[3] = 24'hF80000;   // end of screen memory wraps to zero
      foreach (bases[i]) begin
         set_frame_base(bases[i]);
         run_random(340, 1'b0);
      end

      drain_responses();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### files.f
hdl/rofr_pkg.sv
hdl/rofr_front.sv
hdl/rofr_queue.sv
hdl/rofr_back.sv
hdl/rect_outline_fill_rasterizer_unit.sv
hdl/rofr_checker.sv
verif/tb_rect_outline_fill_rasterizer_unit.sv
